// ----- design/fp32as_pkg.sv -----
// ----------------------------------------------------------------------------
// fp32as_pkg: shared constants and types for the single-precision adder
// Field positions, datapath width and the aligned-operand record.
// ----------------------------------------------------------------------------
package fp32as_pkg;

  localparam int WORD_W = 32;
  localparam int SGN_BIT = 31;
  localparam int FRAC_W = 23;
  localparam int EXP_W = 8;
  localparam int DP_W = 25;
  localparam int SH_W = 5;

  typedef enum logic {
    MODE_ADD = 1'b0,
    MODE_SUB = 1'b1
  } mode_t;

  // Aligned operands handed from the align stage to the normalize stage
  typedef struct packed {
    logic              unlike;
    logic              sign_a;
    logic [EXP_W-1:0]  exp;
    logic [DP_W-1:0]   base_val;
    logic [DP_W-1:0]   aligned_val;
  } align_t;

endpackage

// ----- design/fp32as_align.sv -----
// ----------------------------------------------------------------------------
// fp32as_align: unpack, sign-fold and exponent alignment
// Picks the larger-exponent operand and right-shifts the other with round-up.
// ----------------------------------------------------------------------------
module fp32as_align (
  input  logic                     mode,
  input  logic [31:0]              operand_a,
  input  logic [31:0]              operand_b,
  output fp32as_pkg::align_t       aln
);
  import fp32as_pkg::*;

  logic [WORD_W-1:0] b_eff;
  logic              sa, sb, a_small, round_bit;
  logic [EXP_W-1:0]  ea, eb, diff;
  logic [DP_W-1:0]   va, vb, sm, shifted, fill;
  logic [SH_W-1:0]   sh;

  always_comb begin
    // subtract flips b's sign
    b_eff = operand_b ^ {(mode == MODE_SUB), {(WORD_W-1){1'b0}}};
    sa = operand_a[SGN_BIT];
    sb = b_eff[SGN_BIT];
    ea = operand_a[SGN_BIT-1:FRAC_W];
    eb = b_eff[SGN_BIT-1:FRAC_W];
    va = {2'b01, operand_a[FRAC_W-1:0]};
    vb = {2'b01, b_eff[FRAC_W-1:0]};
    aln.unlike = sa ^ sb;
    aln.sign_a = sa;
    // two's complement for negative operands when signs differ
    if (aln.unlike && sa) va = ~va + DP_W'(1);
    if (aln.unlike && sb) vb = ~vb + DP_W'(1);
    a_small = ea < eb;
    diff = a_small ? (eb - ea) : (ea - eb);
    aln.exp = a_small ? eb : ea;
    aln.base_val = a_small ? vb : va;
    sm = a_small ? va : vb;
    sh = diff[SH_W-1:0];
    // arithmetic shift with round-up on the last bit out
    fill = (aln.unlike && sm[DP_W-1]) ? ~({DP_W{1'b1}} >> sh) : '0;
    shifted = (sm >> sh) | fill;
    round_bit = (sh != '0) ? sm[sh - 1'b1] : 1'b0;
    if (diff >= EXP_W'(DP_W)) aln.aligned_val = '0;
    else aln.aligned_val = shifted + DP_W'(round_bit);
  end

endmodule

// ----- design/fp32as_norm.sv -----
// ----------------------------------------------------------------------------
// fp32as_norm: significand add and normalization
// Adds aligned values, resolves sign, normalizes and packs the result word.
// ----------------------------------------------------------------------------
module fp32as_norm (
  input  fp32as_pkg::align_t aln,
  output logic [31:0]        result_word
);
  import fp32as_pkg::*;

  logic [DP_W-1:0]  sum, mag, shl;
  logic [4:0]       lz;
  logic             sign;
  logic [EXP_W-1:0] ex;
  logic [FRAC_W-1:0] frac;

  always_comb begin
    sum = aln.aligned_val + aln.base_val;
    mag = sum;
    lz = 5'd24;
    shl = '0;
    if (aln.unlike) begin
      sign = sum[DP_W-1];
      if (sign) mag = ~sum + DP_W'(1);
      // leading-zero count over bits 23..0
      for (int i = 0; i <= FRAC_W; i++) begin
        if (mag[i]) lz = 5'(FRAC_W - i);
      end
      shl = mag << lz;
      ex = aln.exp - EXP_W'(lz);
      frac = shl[FRAC_W-1:0];
    end else begin
      sign = aln.sign_a;
      if (sum[DP_W-1]) begin
        ex = aln.exp + EXP_W'(1);
        frac = sum[FRAC_W:1];
      end else begin
        ex = aln.exp;
        frac = sum[FRAC_W-1:0];
      end
    end
    result_word = {sign, ex, frac};
  end

endmodule

// ----- design/fp32_add_sub.sv -----
// ----------------------------------------------------------------------------
// fp32_add_sub: single-precision floating-point adder/subtracter
// Input register, align and normalize logic, result register.
// ----------------------------------------------------------------------------
//  channel   ports                                    direction
//  input     start, in_mode, in_operand_a/b (busy: out)     in
//  result    out_valid, out_result_word               out
//
// One transaction per cycle; busy is always low.
// A start's operands pass the input register, then the result register;
// the result is valid for one cycle.
// Synchronous active-low reset clears the valid pipeline; no stalls.
module fp32_add_sub (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  output logic [31:0] out_result_word
);
  import fp32as_pkg::*;

  logic        vld_in_r, vld_out_r;
  logic        mode_r;
  logic [31:0] a_r, b_r, res_r, res_nxt;
  align_t      aln;

  assign busy = 1'b0;

  // input register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_in_r <= 1'b0;
      vld_out_r <= 1'b0;
    end else begin
      vld_in_r <= start;
      vld_out_r <= vld_in_r;
    end
    mode_r <= in_mode;
    a_r <= in_operand_a;
    b_r <= in_operand_b;
    res_r <= res_nxt;
  end

  fp32as_align u_align (
    .mode(mode_r), .operand_a(a_r), .operand_b(b_r), .aln(aln)
  );

  fp32as_norm u_norm (
    .aln(aln), .result_word(res_nxt)
  );

  assign out_valid = vld_out_r;
  assign out_result_word = res_r;

endmodule
